// ----- hdl/pis_pkg.sv -----
`default_nettype none
package pis_pkg;

    localparam int COORD_W  = 32;
    localparam int SPEED_W  = 31;
    localparam int TOL_W    = 8;
    localparam int STATUS_W = 2;
    localparam int DEF_TIME_FRAC_BITS = 16;

    // Square root of a 128-bit radicand gives a 64-bit root.
    localparam int ROOT_W = 64;
    localparam int RAD_W  = 2 * ROOT_W;
    // s^2 - |v|^2 fits in 62 bits; |d.v| fits in 64 bits.
    localparam int DEN_W  = 62;
    localparam int BM_W   = 64;
    // Numerator before the time scaling: root + |d.v|.
    localparam int NUMR_W = 65;
    // Time quotient bits below saturation.
    localparam int QUO_W  = 31;
    localparam logic [QUO_W-1:0] TIME_MAX = {QUO_W{1'b1}};

    localparam logic [STATUS_W-1:0] ST_GENERAL  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_FAST = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERLAP  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STILL    = 2'd3;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] sh;
        logic [2:0][COORD_W-1:0] tg;
        logic [2:0][COORD_W-1:0] v;
        logic [SPEED_W-1:0]      s;
    } t_query;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] tg;
        logic [2:0][COORD_W-1:0] v;
        logic [SPEED_W-1:0]      s;
        logic [DEN_W-1:0]        a;
        logic [BM_W-1:0]         bm;
        logic                    bneg;
        logic [STATUS_W-1:0]     status;
    } t_side;

endpackage
`default_nettype wire

// ----- hdl/pis_in_if.sv -----
`default_nettype none
interface pis_in_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] shooter_x;
    logic signed [31:0] shooter_y;
    logic signed [31:0] shooter_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] target_vel_x;
    logic signed [31:0] target_vel_y;
    logic signed [31:0] target_vel_z;
    logic [30:0] projectile_speed;

    modport source (
        output valid, shooter_x, shooter_y, shooter_z, target_x, target_y, target_z,
               target_vel_x, target_vel_y, target_vel_z, projectile_speed,
        input  ready
    );
    modport sink (
        input  valid, shooter_x, shooter_y, shooter_z, target_x, target_y, target_z,
               target_vel_x, target_vel_y, target_vel_z, projectile_speed,
        output ready
    );
endinterface
`default_nettype wire

// ----- hdl/pis_out_if.sv -----
`default_nettype none
interface pis_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic signed [31:0] hit_time;
    logic [1:0]  solve_status;

    modport source (
        output valid, hit_x, hit_y, hit_z, hit_time, solve_status,
        input  ready
    );
    modport sink (
        input  valid, hit_x, hit_y, hit_z, hit_time, solve_status,
        output ready
    );
endinterface
`default_nettype wire

// ----- hdl/projectile_intercept_solver.sv -----
// Throughput: one word per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// Depth is set by the 64-stage square root and 32-stage divider pipelines.
// Reset (synchronous, active low) clears all valid bits and sets the
// near-zero tolerance to 0.
`default_nettype none
module projectile_intercept_solver #(
    parameter int TIME_FRAC_BITS = pis_pkg::DEF_TIME_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [pis_pkg::TOL_W-1:0]   i_cfg_wr_data,
    pis_in_if.sink                      i_in,
    pis_out_if.source                   o_out
);

    localparam logic [31:0] T_NEG_ONE = 32'(-(64'(1) << TIME_FRAC_BITS));

    logic [pis_pkg::TOL_W-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    logic en;
    logic r_o_vld;

    assign en         = !r_o_vld || o_out.ready;
    assign i_in.ready = en;

    pis_pkg::t_query q;
    assign q.sh = {i_in.shooter_z, i_in.shooter_y, i_in.shooter_x};
    assign q.tg = {i_in.target_z, i_in.target_y, i_in.target_x};
    assign q.v  = {i_in.target_vel_z, i_in.target_vel_y, i_in.target_vel_x};
    assign q.s  = i_in.projectile_speed;

    logic                           f_vld;
    logic [pis_pkg::RAD_W-1:0]      f_rad;
    pis_pkg::t_side                 f_side;

    pis_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in.valid),
        .i_q     (q),
        .i_tol   (r_tol),
        .o_vld   (f_vld),
        .o_rad   (f_rad),
        .o_side  (f_side)
    );

    logic                           s_vld;
    logic [pis_pkg::ROOT_W-1:0]     s_root;
    pis_pkg::t_side                 s_side;

    pis_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_rad   (f_rad),
        .i_side  (f_side),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // Numerator and divisor: root/s when the target is still, otherwise
    // (root + d.v)/(s^2 - |v|^2) with a negative sum clamped to zero.
    logic [pis_pkg::NUMR_W-1:0] n_num;
    logic [pis_pkg::DEN_W-1:0]  n_den;

    always_comb begin
        if (s_side.status == pis_pkg::ST_STILL) begin
            n_num = pis_pkg::NUMR_W'(s_root);
            n_den = pis_pkg::DEN_W'(s_side.s);
        end else if (s_side.bneg) begin
            n_num = (s_root >= s_side.bm) ? pis_pkg::NUMR_W'(s_root - s_side.bm) : '0;
            n_den = s_side.a;
        end else begin
            n_num = pis_pkg::NUMR_W'(s_root) + pis_pkg::NUMR_W'(s_side.bm);
            n_den = s_side.a;
        end
    end

    logic                       r_n_vld;
    logic [pis_pkg::NUMR_W-1:0] r_n_num;
    logic [pis_pkg::DEN_W-1:0]  r_n_den;
    pis_pkg::t_side             r_n_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
        end else if (en) begin
            r_n_vld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_num  <= n_num;
            r_n_den  <= n_den;
            r_n_side <= s_side;
        end
    end

    logic                       d_vld;
    logic [pis_pkg::QUO_W-1:0]  d_time;
    pis_pkg::t_side             d_side;

    pis_div #(
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_n_vld),
        .i_num   (r_n_num),
        .i_den   (r_n_den),
        .i_side  (r_n_side),
        .o_vld   (d_vld),
        .o_time  (d_time),
        .o_side  (d_side)
    );

    // Final time and the velocity-times-time products.
    logic [31:0] n_time;

    always_comb begin
        unique case (d_side.status)
            pis_pkg::ST_TOO_FAST: n_time = T_NEG_ONE;
            pis_pkg::ST_OVERLAP:  n_time = '0;
            pis_pkg::ST_STILL:    n_time = {1'b0, d_time};
            pis_pkg::ST_GENERAL:  n_time = {1'b0, d_time};
            default:              n_time = '0;
        endcase
    end

    logic                        r_a_vld;
    logic signed [2:0][63:0]     r_a_p;
    logic [2:0][31:0]            r_a_tg;
    logic [31:0]                 r_a_time;
    logic [pis_pkg::STATUS_W-1:0] r_a_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_p[i] <= $signed(d_side.v[i]) * $signed({1'b0, d_time});
            end
            r_a_tg     <= d_side.tg;
            r_a_time   <= n_time;
            r_a_status <= d_side.status;
        end
    end

    // Aim point for the general status (others keep the target): target +
    // floor(v*t / 2^frac), saturated to 32 bits. Packed array elements
    // read unsigned; the product is cast signed for the arithmetic shift.
    logic [2:0][31:0] n_hit;

    always_comb begin
        logic signed [63:0] off;
        logic signed [64:0] hs;
        for (int i = 0; i < 3; i++) begin
            off = $signed(r_a_p[i]) >>> TIME_FRAC_BITS;
            hs  = 65'(off) + 65'(signed'(r_a_tg[i]));
            if (r_a_status != pis_pkg::ST_GENERAL) begin
                n_hit[i] = r_a_tg[i];
            end else if (hs > 65'sd2147483647) begin
                n_hit[i] = 32'h7FFF_FFFF;
            end else if (hs < -65'sd2147483648) begin
                n_hit[i] = 32'h8000_0000;
            end else begin
                n_hit[i] = hs[31:0];
            end
        end
    end

    logic [2:0][31:0]             r_o_hit;
    logic [31:0]                  r_o_time;
    logic [pis_pkg::STATUS_W-1:0] r_o_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_hit    <= n_hit;
            r_o_time   <= r_a_time;
            r_o_status <= r_a_status;
        end
    end

    assign o_out.valid        = r_o_vld;
    assign o_out.hit_x        = r_o_hit[0];
    assign o_out.hit_y        = r_o_hit[1];
    assign o_out.hit_z        = r_o_hit[2];
    assign o_out.hit_time     = r_o_time;
    assign o_out.solve_status = r_o_status;

    a_too_fast_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.solve_status == pis_pkg::ST_TOO_FAST
        |-> o_out.hit_time == T_NEG_ONE)
        else $error("too-fast word without minus-one time");

    a_overlap_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.solve_status == pis_pkg::ST_OVERLAP
        |-> o_out.hit_time == 32'sd0)
        else $error("overlapping word with nonzero time");

    a_solved_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.solve_status == pis_pkg::ST_GENERAL
                        || o_out.solve_status == pis_pkg::ST_STILL)
        |-> !o_out.hit_time[31])
        else $error("solved word with negative time");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire

// ----- hdl/pis_front.sv -----
`default_nettype none
module pis_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  pis_pkg::t_query               i_q,
    input  logic [pis_pkg::TOL_W-1:0]     i_tol,
    output logic                          o_vld,
    output logic [pis_pkg::RAD_W-1:0]     o_rad,
    output pis_pkg::t_side                o_side
);

    // Stage 1: separation vector.
    logic                 r1_vld;
    logic [2:0][32:0]     r1_d;
    logic [2:0][31:0]     r1_v;
    logic [2:0][31:0]     r1_tg;
    logic [30:0]          r1_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_d[i] <= 33'(signed'(i_q.tg[i])) - 33'(signed'(i_q.sh[i]));
            end
            r1_v  <= i_q.v;
            r1_tg <= i_q.tg;
            r1_s  <= i_q.s;
        end
    end

    // Stage 2: magnitudes and per-axis products.
    logic [2:0][32:0] mag_d;
    logic [2:0][31:0] mag_v;
    logic             n2_dz;
    logic             n2_vz;

    always_comb begin
        n2_dz = 1'b1;
        n2_vz = 1'b1;
        for (int i = 0; i < 3; i++) begin
            mag_d[i] = r1_d[i][32] ? 33'(-r1_d[i]) : r1_d[i];
            mag_v[i] = r1_v[i][31] ? 32'(-r1_v[i]) : r1_v[i];
            if (mag_d[i] > 33'(i_tol)) n2_dz = 1'b0;
            if (mag_v[i] > 32'(i_tol)) n2_vz = 1'b0;
        end
    end

    logic                 r2_vld;
    logic [2:0][65:0]     r2_dd;
    logic [2:0][64:0]     r2_dv;
    logic [2:0]           r2_dvneg;
    logic [2:0][63:0]     r2_vv;
    logic [61:0]          r2_ss;
    logic                 r2_dz;
    logic                 r2_vz;
    logic [2:0][31:0]     r2_v;
    logic [2:0][31:0]     r2_tg;
    logic [30:0]          r2_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r2_dd[i]    <= 66'(mag_d[i]) * 66'(mag_d[i]);
                r2_dv[i]    <= 65'(mag_d[i]) * 65'(mag_v[i]);
                r2_dvneg[i] <= r1_d[i][32] ^ r1_v[i][31];
                r2_vv[i]    <= 64'(mag_v[i]) * 64'(mag_v[i]);
            end
            r2_ss <= 62'(r1_s) * 62'(r1_s);
            r2_dz <= n2_dz;
            r2_vz <= n2_vz;
            r2_v  <= r1_v;
            r2_tg <= r1_tg;
            r2_s  <= r1_s;
        end
    end

    // Stage 3: sums of the three axes.
    logic [65:0] n3_c;
    logic [66:0] n3_b;
    logic [63:0] n3_vv;

    always_comb begin
        n3_c  = '0;
        n3_b  = '0;
        n3_vv = '0;
        for (int i = 0; i < 3; i++) begin
            n3_c  = n3_c + r2_dd[i];
            n3_b  = r2_dvneg[i] ? n3_b - 67'(r2_dv[i]) : n3_b + 67'(r2_dv[i]);
            n3_vv = n3_vv + r2_vv[i];
        end
    end

    logic                 r3_vld;
    logic [65:0]          r3_c;
    logic [66:0]          r3_b;
    logic [63:0]          r3_vv;
    logic [61:0]          r3_ss;
    logic                 r3_dz;
    logic                 r3_vz;
    logic [2:0][31:0]     r3_v;
    logic [2:0][31:0]     r3_tg;
    logic [30:0]          r3_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_c  <= n3_c;
            r3_b  <= n3_b;
            r3_vv <= n3_vv;
            r3_ss <= r2_ss;
            r3_dz <= r2_dz;
            r3_vz <= r2_vz;
            r3_v  <= r2_v;
            r3_tg <= r2_tg;
            r3_s  <= r2_s;
        end
    end

    // Stage 4: classify and form the quadratic's coefficients.
    pis_pkg::t_side n4_side;
    logic           too_fast;

    always_comb begin
        too_fast       = r3_vv >= 64'(r3_ss);
        n4_side.tg     = r3_tg;
        n4_side.v      = r3_v;
        n4_side.s      = r3_s;
        n4_side.a      = 62'(64'(r3_ss) - r3_vv);
        n4_side.bneg   = r3_b[66];
        n4_side.bm     = r3_b[66] ? 64'(-r3_b) : 64'(r3_b);
        priority if (too_fast) begin
            n4_side.status = pis_pkg::ST_TOO_FAST;
        end else if (r3_dz) begin
            n4_side.status = pis_pkg::ST_OVERLAP;
        end else if (r3_vz) begin
            n4_side.status = pis_pkg::ST_STILL;
        end else begin
            n4_side.status = pis_pkg::ST_GENERAL;
        end
    end

    logic           r4_vld;
    logic [65:0]    r4_c;
    pis_pkg::t_side r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_c    <= r3_c;
            r4_side <= n4_side;
        end
    end

    // Stage 5: partial products of b^2 and a*c.
    logic           r5_vld;
    logic [63:0]    r5_bhh, r5_bhl, r5_bll;
    logic [63:0]    r5_ahh, r5_ahl, r5_alh, r5_all;
    logic [65:0]    r5_c;
    pis_pkg::t_side r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_bhh  <= 64'(r4_side.bm[63:32]) * 64'(r4_side.bm[63:32]);
            r5_bhl  <= 64'(r4_side.bm[63:32]) * 64'(r4_side.bm[31:0]);
            r5_bll  <= 64'(r4_side.bm[31:0]) * 64'(r4_side.bm[31:0]);
            r5_ahh  <= 64'(r4_side.a[61:31]) * 64'(r4_c[65:33]);
            r5_ahl  <= 64'(r4_side.a[61:31]) * 64'(r4_c[32:0]);
            r5_alh  <= 64'(r4_side.a[30:0]) * 64'(r4_c[65:33]);
            r5_all  <= 64'(r4_side.a[30:0]) * 64'(r4_c[32:0]);
            r5_c    <= r4_c;
            r5_side <= r4_side;
        end
    end

    // Stage 6: assemble the two 128-bit products.
    logic           r6_vld;
    logic [127:0]   r6_bm2;
    logic [127:0]   r6_ac;
    logic [65:0]    r6_c;
    pis_pkg::t_side r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_bm2  <= (128'(r5_bhh) << 64) + (128'(r5_bhl) << 33) + 128'(r5_bll);
            r6_ac   <= (128'(r5_ahh) << 64) + (128'(r5_ahl) << 31)
                     + (128'(r5_alh) << 33) + 128'(r5_all);
            r6_c    <= r5_c;
            r6_side <= r5_side;
        end
    end

    // Stage 7: pick the radicand for the root unit.
    logic           r7_vld;
    logic [127:0]   r7_rad;
    pis_pkg::t_side r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (i_en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_rad  <= (r6_side.status == pis_pkg::ST_STILL) ? 128'(r6_c) : r6_bm2 + r6_ac;
            r7_side <= r6_side;
        end
    end

    assign o_vld  = r7_vld;
    assign o_rad  = r7_rad;
    assign o_side = r7_side;

endmodule
`default_nettype wire

// ----- hdl/pis_sqrt.sv -----
`default_nettype none
module pis_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  logic [pis_pkg::RAD_W-1:0]      i_rad,
    input  pis_pkg::t_side                 i_side,
    output logic                           o_vld,
    output logic [pis_pkg::ROOT_W-1:0]     o_root,
    output pis_pkg::t_side                 o_side
);

    localparam int STEPS = pis_pkg::ROOT_W;
    localparam int REM_W = pis_pkg::ROOT_W + 2;
    localparam int RW    = pis_pkg::RAD_W;
    localparam int QW    = pis_pkg::ROOT_W;

    logic [STEPS-1:0] r_vld;
    logic [REM_W-1:0] r_rem  [STEPS];
    logic [QW-1:0]    r_root [STEPS];
    logic [RW-1:0]    r_rad  [STEPS];
    pis_pkg::t_side   r_side [STEPS];

    // One root bit per stage, two radicand bits shifted in each time.
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [REM_W-1:0] p_rem;
        logic [QW-1:0]    p_root;
        logic [RW-1:0]    p_rad;
        pis_pkg::t_side   p_side;
        logic             p_vld;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             take;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_side = i_side;
            assign p_vld  = i_vld;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_side = r_side[k-1];
            assign p_vld  = r_vld[k-1];
        end

        assign rem_sh = {p_rem[REM_W-3:0], p_rad[RW-1 -: 2]};
        assign trial  = {p_root, 2'b01};
        assign take   = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? rem_sh - trial : rem_sh;
                r_root[k] <= {p_root[QW-2:0], take};
                r_rad[k]  <= {p_rad[RW-3:0], 2'b00};
                r_side[k] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_root = r_root[STEPS-1];
    assign o_side = r_side[STEPS-1];

endmodule
`default_nettype wire

// ----- hdl/pis_div.sv -----
`default_nettype none
module pis_div #(
    parameter int TIME_FRAC_BITS = pis_pkg::DEF_TIME_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  logic [pis_pkg::NUMR_W-1:0]     i_num,
    input  logic [pis_pkg::DEN_W-1:0]      i_den,
    input  pis_pkg::t_side                 i_side,
    output logic                           o_vld,
    output logic [pis_pkg::QUO_W-1:0]      o_time,
    output pis_pkg::t_side                 o_side
);

    localparam int NUM_W = pis_pkg::NUMR_W + TIME_FRAC_BITS;
    localparam int DW    = pis_pkg::DEN_W;
    localparam int QB    = pis_pkg::QUO_W;
    localparam int CMP_W = (NUM_W > DW + QB) ? NUM_W : DW + QB;

    // Stage 0: the quotient saturates exactly when num >= den * 2^QB.
    logic [NUM_W-1:0] num_full;
    assign num_full = {i_num, {TIME_FRAC_BITS{1'b0}}};

    logic             r0_vld;
    logic [NUM_W-1:0] r0_rem;
    logic             r0_big;
    logic [DW-1:0]    r0_den;
    pis_pkg::t_side   r0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_rem  <= num_full;
            r0_big  <= CMP_W'(num_full) >= (CMP_W'(i_den) << QB);
            r0_den  <= i_den;
            r0_side <= i_side;
        end
    end

    logic [QB-1:0]    r_vld;
    logic [NUM_W-1:0] r_rem  [QB];
    logic [QB-1:0]    r_q    [QB];
    logic [QB-1:0]    r_big;
    logic [DW-1:0]    r_den  [QB];
    pis_pkg::t_side   r_side [QB];

    // Restoring division, most significant quotient bit first.
    for (genvar j = 0; j < QB; j++) begin : g_step
        localparam int BIT = QB - 1 - j;
        logic [NUM_W-1:0] p_rem;
        logic [QB-1:0]    p_q;
        logic             p_big;
        logic [DW-1:0]    p_den;
        pis_pkg::t_side   p_side;
        logic             p_vld;
        logic [CMP_W-1:0] shifted;
        logic             take;

        if (j == 0) begin : g_first
            assign p_rem  = r0_rem;
            assign p_q    = '0;
            assign p_big  = r0_big;
            assign p_den  = r0_den;
            assign p_side = r0_side;
            assign p_vld  = r0_vld;
        end else begin : g_next
            assign p_rem  = r_rem[j-1];
            assign p_q    = r_q[j-1];
            assign p_big  = r_big[j-1];
            assign p_den  = r_den[j-1];
            assign p_side = r_side[j-1];
            assign p_vld  = r_vld[j-1];
        end

        assign shifted = CMP_W'(p_den) << BIT;
        assign take    = CMP_W'(p_rem) >= shifted;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= take ? NUM_W'(CMP_W'(p_rem) - shifted) : p_rem;
                r_q[j]    <= {p_q[QB-2:0], take};
                r_big[j]  <= p_big;
                r_den[j]  <= p_den;
                r_side[j] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[QB-1];
    assign o_time = r_big[QB-1] ? pis_pkg::TIME_MAX : r_q[QB-1];
    assign o_side = r_side[QB-1];

endmodule
`default_nettype wire

// ----- sim/tb_intercept_checker.sv -----
`default_nettype none
module tb_intercept_checker (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_wr_en,
    input  wire logic [pis_pkg::TOL_W-1:0] i_cfg_wr_data,
    pis_in_if          i_in,
    pis_out_if         i_out,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] hx;
        logic [31:0] hy;
        logic [31:0] hz;
        logic [31:0] ht;
        logic [1:0]  st;
    } t_solution;

    localparam int TFB = pis_pkg::DEF_TIME_FRAC_BITS;
    localparam logic [63:0] TMAX64 = 64'h7FFF_FFFF;

    logic [7:0] tol;
    t_solution  solutions_due[$];

    function automatic logic [63:0] floor_sqrt(logic [127:0] x);
        logic [63:0]  root;
        logic [63:0]  cand;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= x) root = cand;
        end
        return root;
    endfunction

    function automatic logic [31:0] aim_coord(logic signed [31:0] tgt,
                                               logic signed [31:0] vel,
                                               logic [63:0] t);
        logic signed [63:0] prod;
        logic signed [63:0] h;
        prod = 64'(vel) * $signed(t);
        h = 64'(tgt) + (prod >>> TFB);
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        return h[31:0];
    endfunction

    function automatic t_solution solve_intercept(logic [31:0] sh [3], logic [31:0] tg [3],
                                                  logic [31:0] vl [3], logic [30:0] spd);
        t_solution r;
        logic signed [63:0]  d [3];
        logic signed [63:0]  v [3];
        logic [63:0]         vv;
        logic [63:0]         ss;
        logic [63:0]         t;
        logic signed [129:0] bdot;
        logic [127:0]        c;
        logic [63:0]         a;
        logic [63:0]         bm;
        logic [127:0]        num;
        logic [63:0]         root;
        logic [127:0]        quo;
        bit dz;
        bit vz;
        vv = 0;
        dz = 1;
        vz = 1;
        bdot = 0;
        c = 0;
        ss = 64'(spd) * 64'(spd);
        for (int i = 0; i < 3; i++) begin
            v[i] = 64'($signed(vl[i]));
            d[i] = 64'($signed(tg[i])) - 64'($signed(sh[i]));
            vv += 64'(v[i] * v[i]);
            if ((d[i] < 0 ? -d[i] : d[i]) > 64'(tol)) dz = 0;
            if ((v[i] < 0 ? -v[i] : v[i]) > 64'(tol)) vz = 0;
            // A squared separation can exceed the signed 64-bit range.
            c += 128'(d[i]) * 128'(d[i]);
            bdot += 130'(d[i] * v[i]);
        end
        r.hx = tg[0];
        r.hy = tg[1];
        r.hz = tg[2];
        if (vv >= ss) begin
            r.st = pis_pkg::ST_TOO_FAST;
            t = 64'h0000_0000_FFFF_0000;
        end else if (dz) begin
            r.st = pis_pkg::ST_OVERLAP;
            t = 0;
        end else if (vz) begin
            r.st = pis_pkg::ST_STILL;
            t = (floor_sqrt(c) << TFB) / 64'(spd);
            if (t > TMAX64) t = TMAX64;
        end else begin
            r.st = pis_pkg::ST_GENERAL;
            a = ss - vv;
            bm = bdot < 0 ? 64'(-bdot) : 64'(bdot);
            root = floor_sqrt(128'(bm) * 128'(bm) + 128'(a) * c);
            if (bdot < 0) num = root >= bm ? 128'(root - bm) : 128'd0;
            else num = 128'(root) + 128'(bm);
            quo = (num << TFB) / 128'(a);
            t = quo > 128'(TMAX64) ? TMAX64 : quo[63:0];
            r.hx = aim_coord(tg[0], vl[0], t);
            r.hy = aim_coord(tg[1], vl[1], t);
            r.hz = aim_coord(tg[2], vl[2], t);
        end
        r.ht = t[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        logic [31:0] sh [3];
        logic [31:0] tg [3];
        logic [31:0] vl [3];
        t_solution got;
        t_solution want;
        if (!i_rst_n) begin
            tol <= '0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_wr_en) tol <= i_cfg_wr_data;
            if (i_in.valid && i_in.ready) begin
                sh = '{i_in.shooter_x, i_in.shooter_y, i_in.shooter_z};
                tg = '{i_in.target_x, i_in.target_y, i_in.target_z};
                vl = '{i_in.target_vel_x, i_in.target_vel_y, i_in.target_vel_z};
                solutions_due.push_back(solve_intercept(sh, tg, vl, i_in.projectile_speed));
            end
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.hit_x, i_out.hit_y, i_out.hit_z, i_out.hit_time,
                        i_out.solve_status};
                if (solutions_due.size() == 0) begin
                    $display("%0t: unexpected word, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = solutions_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected x=%h y=%h z=%h t=%h st=%0d",
                                 $time, want.hx, want.hy, want.hz, want.ht, want.st);
                        $display("%0t:          actual   x=%h y=%h z=%h t=%h st=%0d",
                                 $time, got.hx, got.hy, got.hz, got.ht, got.st);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    assign o_pending = solutions_due.size();
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 106;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wr_en = 0;
    logic [pis_pkg::TOL_W-1:0] cfg_wr_data = '0;
    int fail_count;
    int pending;
    int cycle_count = 0;
    bit idle_free = 0;
    bit long_hold = 0;

    pis_in_if  in_ch();
    pis_out_if out_ch();

    projectile_intercept_solver DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    tb_intercept_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data), .i_in(in_ch), .i_out(out_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial begin
        in_ch.valid = 0;
        {in_ch.shooter_x, in_ch.shooter_y, in_ch.shooter_z} = '0;
        {in_ch.target_x, in_ch.target_y, in_ch.target_z} = '0;
        {in_ch.target_vel_x, in_ch.target_vel_y, in_ch.target_vel_z} = '0;
        in_ch.projectile_speed = '0;
        out_ch.ready = 0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the pipeline backs up.
    always @(negedge clk) begin
        if (long_hold) out_ch.ready <= 0;
        else if (idle_free) out_ch.ready <= 1;
        else out_ch.ready <= ($urandom_range(99) >= 35);
    end

    initial begin
        wait (cycle_count == 3000);
        @(negedge clk);
        long_hold = 1;
        repeat (400) @(negedge clk);
        long_hold = 0;
    end

    function automatic logic [31:0] pick_coord(int mode);
        case (mode)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(600)) - 300);
            3: return 32'($signed($urandom_range(200000)) - 100000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_query(logic [31:0] sh [3], logic [31:0] tg [3],
                              logic [31:0] vl [3], logic [30:0] spd);
        bit gap;
        gap = !idle_free && ($urandom_range(99) < 35);
        while (gap) begin
            in_ch.valid <= 0;
            @(negedge clk);
            gap = !idle_free && ($urandom_range(99) < 35);
        end
        in_ch.valid <= 1;
        {in_ch.shooter_x, in_ch.shooter_y, in_ch.shooter_z} <= {sh[0], sh[1], sh[2]};
        {in_ch.target_x, in_ch.target_y, in_ch.target_z} <= {tg[0], tg[1], tg[2]};
        {in_ch.target_vel_x, in_ch.target_vel_y, in_ch.target_vel_z} <= {vl[0], vl[1], vl[2]};
        in_ch.projectile_speed <= spd;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_query(int style);
        logic [31:0] sh [3];
        logic [31:0] tg [3];
        logic [31:0] vl [3];
        logic [30:0] spd;
        int m;
        m = $urandom_range(4);
        for (int i = 0; i < 3; i++) begin
            sh[i] = pick_coord($urandom_range(9) < 1 ? m : 3 + $urandom_range(1));
            tg[i] = (style == 1) ? sh[i] + pick_coord(2) : pick_coord(m == 2 ? 2 : 4);
            if ($urandom_range(1)) tg[i] = sh[i] + pick_coord(3);
            vl[i] = (style == 2) ? pick_coord(2) : pick_coord(m);
            if (style == 0 && $urandom_range(1)) vl[i] = 32'($signed(vl[i]) >>> 12);
        end
        case ($urandom_range(3))
            0: spd = 31'($urandom);
            1: spd = 31'h7FFF_FFFF;
            2: spd = 31'($urandom_range(3000));
            default: spd = 31'($urandom) | 31'h4000_0000;
        endcase
        send_query(sh, tg, vl, spd);
    endtask

    task automatic drain_and_config(logic [pis_pkg::TOL_W-1:0] value);
        in_ch.valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        cfg_wr_en <= 1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 0;
    endtask

    initial begin
        logic [31:0] z3 [3];
        logic [31:0] hi3 [3];
        logic [31:0] lo3 [3];
        logic [31:0] one3 [3];
        logic [pis_pkg::TOL_W-1:0] tol_plan [5];
        z3 = '{0, 0, 0};
        hi3 = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        lo3 = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        one3 = '{32'h100, 32'hFFFF_FF00, 32'h100};
        tol_plan = '{8'd0, 8'd255, 8'd3, 8'd40, 8'd128};
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed words: each status code, extremes and saturation.
        send_query(z3, z3, z3, 31'd0);
        send_query(z3, one3, hi3, 31'h7FFF_FFFF);
        send_query(z3, z3, one3, 31'd1000);
        send_query(z3, one3, z3, 31'd1000);
        send_query(z3, hi3, z3, 31'd1);
        send_query(lo3, hi3, z3, 31'd1);
        send_query(hi3, lo3, z3, 31'h7FFF_FFFF);
        send_query(lo3, hi3, one3, 31'h7FFF_FFFF);
        send_query(hi3, lo3, one3, 31'h7FFF_FFFF);
        send_query(lo3, hi3, '{32'h100, 0, 0}, 31'h101);
        send_query(hi3, lo3, '{32'hFFFF_FF00, 0, 0}, 31'h101);
        send_query(z3, one3, '{32'hFFFF_FF00, 32'h100, 32'hFFFF_FF00}, 31'h200);
        send_query(z3, one3, one3, 31'h200);
        send_query(hi3, hi3, hi3, 31'h7FFF_FFFF);
        send_query(z3, '{5, 0, 0}, '{0, 3, 0}, 31'd100);
        drain_and_config(8'd255);
        send_query(z3, '{255, 32'hFFFF_FF01, 255}, one3, 31'h7FFF_FFFF);
        send_query(z3, '{256, 0, 0}, '{255, 32'hFFFF_FF01, 0}, 31'd1000);
        send_query(z3, '{255, 0, 0}, one3, 31'd1000);

        for (int ph = 0; ph < 5; ph++) begin
            drain_and_config(tol_plan[ph]);
            idle_free = (ph == 2);
            for (int n = 0; n < 365; n++) random_query(n % 3);
        end
        idle_free = 0;
        in_ch.valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (fail_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
